[hw/rtl/bhs_pkg.sv]
package bhs_pkg;

    // histogram geometry
    localparam int NBINS     = 256;
    localparam int BIN_AW    = 8;
    localparam int DIST_W    = 9;

    // field widths
    localparam int STATUS_W  = 2;
    localparam int TOTAL_W   = 40;
    localparam int STAT_W    = 40;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int SKIP_W    = 32;

    // datapath widths, sized for the widest bin counter
    localparam int CMAX_W    = 32;
    localparam int S_W       = 40;              // sum of bins
    localparam int Q_W       = 72;              // sum of squares
    localparam int V_W       = 81;              // n * sum(c^2) - S^2
    localparam int MB_W      = 40;              // multiplier operand
    localparam int SQ_W      = 98;              // radicand
    localparam int RT_W      = SQ_W / 2;        // root
    localparam int REM_W     = RT_W + 3;        // root remainder
    localparam int DV_W      = 49;              // dividend / quotient
    localparam int NC_W      = CMAX_W + DIST_W; // n * c
    localparam int STEP_W    = 6;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_ON_ALL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_OUTLIERS = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_ALL   = 2'd1,
        ST_SHORT = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic {
        REQ_DATA = 1'b0,
        REQ_END  = 1'b1
    } req_kind_t;

endpackage

[hw/rtl/bhs_req_if.sv]
interface bhs_req_if
    import bhs_pkg::*;
();
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] data_byte;

    modport source (output valid, output req_type, output data_byte, input ready);
    modport sink   (input valid, input req_type, input data_byte, output ready);
endinterface

[hw/rtl/bhs_rsp_if.sv]
interface bhs_rsp_if
    import bhs_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [DIST_W-1:0]   distinct_count;
    logic [TOTAL_W-1:0]  total_count;
    logic [STAT_W-1:0]   mean_q8;
    logic [STAT_W-1:0]   std_dev_q8;
    logic                outliers_valid;
    logic [DIST_W-1:0]   outlier_count;

    modport source (output valid, output status, output distinct_count, output total_count,
                    output mean_q8, output std_dev_q8, output outliers_valid,
                    output outlier_count, input ready);
    modport sink   (input valid, input status, input distinct_count, input total_count,
                    input mean_q8, input std_dev_q8, input outliers_valid,
                    input outlier_count, output ready);
endinterface

[hw/rtl/byte_histogram_stats_unit.sv]
// Channel  Dir  Beat
// req      in   req_type, data_byte (tally a byte or close the run)
// rsp      out  status, distinct_count, total_count, mean_q8, std_dev_q8,
//               outliers_valid, outlier_count
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// A counted byte is read from bin memory, then written back in S_UPD; a skipped
// byte only counts down the skip counter. An end-of-run beat on a nonempty run
// that met its skip count walks all 256 bins through the memory read port, then
// runs the shared serial multiplier twice, the square root and the divider twice;
// the outlier pass adds a second root and walk. Bin memory is never swept:
// per-bin valid flops are all cleared together when a result is loaded. Reset
// is asynchronous, active low. A result waits in the output register; while it
// waits, end-of-run and plain bytes are still taken unless stop_on_all is set.
module byte_histogram_stats_unit
    import bhs_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    bhs_req_if.sink              req,
    bhs_rsp_if.source            rsp,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_UPD, S_SUM, S_MNQ, S_MSS, S_SUB, S_SQ1,
        S_DIVM, S_DIVS, S_SQ2, S_OWALK, S_EMIT
    } state_t;

    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    state_t                  state_reg;

    // configuration
    logic [SKIP_W-1:0]       skip_count_reg;
    logic                    stop_on_all_reg;
    logic                    check_outliers_reg;

    // run state
    logic [SKIP_W-1:0]       skip_left_reg;
    logic [DIST_W-1:0]       distinct_reg;
    logic [TOTAL_W-1:0]      run_total_reg;
    logic [NBINS-1:0]        bin_vld_reg;
    logic [BIN_AW-1:0]       byte_reg;

    // bin memory
    logic [COUNT_WIDTH-1:0]  bin_mem [NBINS];
    logic [COUNT_WIDTH-1:0]  mem_rdata_reg;
    logic                    mem_re;
    logic [BIN_AW-1:0]       mem_raddr;
    logic                    mem_we;
    logic [BIN_AW-1:0]       mem_waddr;
    logic [COUNT_WIDTH-1:0]  mem_wdata;

    // walk pipeline
    logic [BIN_AW:0]         issue_reg;
    logic                    p1_vld_reg;
    logic [BIN_AW-1:0]       p1_idx_reg;
    logic                    p2_vld_reg;
    logic [COUNT_WIDTH-1:0]  c_reg;
    logic                    p3_vld_reg;
    logic [2*CMAX_W-1:0]     sq_reg;
    logic [NC_W-1:0]         nc_reg;
    logic                    nz_reg;

    // statistics
    logic [S_W-1:0]          s_reg;
    logic [Q_W-1:0]          q_reg;
    logic [V_W-1:0]          nq_reg;
    logic [V_W-1:0]          v_reg;
    logic [DIST_W-1:0]       n_reg;
    logic                    ov_reg;
    logic [RT_W-1:0]         r2_reg;
    logic [DIST_W-1:0]       oc_reg;
    logic [STEP_W-1:0]       step_reg;

    // serial multiplier
    logic [V_W-1:0]          mul_a_reg;
    logic [MB_W-1:0]         mul_b_reg;
    logic [V_W-1:0]          mul_acc_reg;

    // serial square root
    logic [SQ_W-1:0]         sq_x_reg;
    logic [REM_W-1:0]        sq_rem_reg;
    logic [RT_W-1:0]         sq_root_reg;

    // serial divider
    logic [DV_W-1:0]         div_q_reg;
    logic [DIST_W-1:0]       div_r_reg;

    // result staging and output register
    status_t                 res_status_reg;
    logic [DIST_W-1:0]       res_dist_reg;
    logic [TOTAL_W-1:0]      res_total_reg;
    logic [STAT_W-1:0]       res_mean_reg;
    logic [STAT_W-1:0]       res_sd_reg;
    logic                    res_ov_reg;

    logic                    out_valid_reg;
    status_t                 out_status_reg;
    logic [DIST_W-1:0]       out_dist_reg;
    logic [TOTAL_W-1:0]      out_total_reg;
    logic [STAT_W-1:0]       out_mean_reg;
    logic [STAT_W-1:0]       out_sd_reg;
    logic                    out_ov_reg;
    logic [DIST_W-1:0]       out_oc_reg;

    logic                    req_fire;
    logic                    emit_go;

    // update path for one byte
    logic [COUNT_WIDTH-1:0]  upd_c;
    logic                    upd_inc;
    logic [DIST_W-1:0]       distinct_next;
    logic [TOTAL_W-1:0]      run_total_next;

    // walk stage two
    logic [COUNT_WIDTH-1:0]  walk_c;
    logic                    walk_done;

    // iterative units, one step
    logic [V_W-1:0]          mul_sum;
    logic [REM_W-1:0]        rem_sh;
    logic [REM_W-1:0]        trial;
    logic                    sq_ge;
    logic [DIST_W:0]         div_sh;
    logic                    div_ge;
    logic [NC_W-1:0]         s_ext;
    logic [NC_W-1:0]         dist_abs;

    assign req.ready = (state_reg == S_IDLE) && (!out_valid_reg || !stop_on_all_reg);
    assign req_fire  = req.valid && req.ready;
    assign emit_go   = (state_reg == S_EMIT) && (!out_valid_reg || rsp.ready);

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.distinct_count = out_dist_reg;
    assign rsp.total_count    = out_total_reg;
    assign rsp.mean_q8        = out_mean_reg;
    assign rsp.std_dev_q8     = out_sd_reg;
    assign rsp.outliers_valid = out_ov_reg;
    assign rsp.outlier_count  = out_oc_reg;

    // bin read-modify-write
    always_comb
    begin
        upd_c          = bin_vld_reg[byte_reg] ? mem_rdata_reg : '0;
        upd_inc        = (upd_c != CNT_MAX);
        distinct_next  = (upd_c == '0) ? distinct_reg + 1'b1 : distinct_reg;
        run_total_next = (upd_inc && run_total_reg != TOTAL_MAX) ? run_total_reg + 1'b1
                                                                  : run_total_reg;
        walk_c         = bin_vld_reg[p1_idx_reg] ? mem_rdata_reg : '0;
        walk_done      = issue_reg[BIN_AW] && !p1_vld_reg && !p2_vld_reg && !p3_vld_reg;
    end

    // memory port control
    always_comb
    begin
        mem_re    = 1'b0;
        mem_raddr = issue_reg[BIN_AW-1:0];
        mem_we    = (state_reg == S_UPD) && upd_inc;
        mem_waddr = byte_reg;
        mem_wdata = upd_c + 1'b1;
        if (state_reg == S_IDLE)
        begin
            mem_re    = req_fire && (req.req_type == REQ_DATA) && (skip_left_reg == '0);
            mem_raddr = req.data_byte;
        end
        else if (state_reg == S_SUM || state_reg == S_OWALK)
        begin
            mem_re = !issue_reg[BIN_AW];
        end
    end

    // shared iterative step logic
    always_comb
    begin
        mul_sum  = mul_b_reg[0] ? mul_acc_reg + mul_a_reg : mul_acc_reg;
        rem_sh   = {sq_rem_reg[REM_W-3:0], sq_x_reg[SQ_W-1 -: 2]};
        trial    = {1'b0, sq_root_reg, 2'b01};
        sq_ge    = (rem_sh >= trial);
        div_sh   = {div_r_reg, div_q_reg[DV_W-1]};
        div_ge   = (div_sh >= {1'b0, n_reg});
        s_ext    = NC_W'(s_reg);
        dist_abs = (nc_reg >= s_ext) ? nc_reg - s_ext : s_ext - nc_reg;
    end

    // bin memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            bin_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            mem_rdata_reg <= bin_mem[mem_raddr];
    end

    // control and datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            skip_count_reg     <= '0;
            stop_on_all_reg    <= 1'b0;
            check_outliers_reg <= 1'b0;
            skip_left_reg      <= '0;
            distinct_reg       <= '0;
            run_total_reg      <= '0;
            bin_vld_reg        <= '0;
            byte_reg           <= '0;
            issue_reg          <= '0;
            p1_vld_reg         <= 1'b0;
            p1_idx_reg         <= '0;
            p2_vld_reg         <= 1'b0;
            c_reg              <= '0;
            p3_vld_reg         <= 1'b0;
            sq_reg             <= '0;
            nc_reg             <= '0;
            nz_reg             <= 1'b0;
            s_reg              <= '0;
            q_reg              <= '0;
            nq_reg             <= '0;
            v_reg              <= '0;
            n_reg              <= '0;
            ov_reg             <= 1'b0;
            r2_reg             <= '0;
            oc_reg             <= '0;
            step_reg           <= '0;
            mul_a_reg          <= '0;
            mul_b_reg          <= '0;
            mul_acc_reg        <= '0;
            sq_x_reg           <= '0;
            sq_rem_reg         <= '0;
            sq_root_reg        <= '0;
            div_q_reg          <= '0;
            div_r_reg          <= '0;
            res_status_reg     <= ST_OK;
            res_dist_reg       <= '0;
            res_total_reg      <= '0;
            res_mean_reg       <= '0;
            res_sd_reg         <= '0;
            res_ov_reg         <= 1'b0;
            out_valid_reg      <= 1'b0;
            out_status_reg     <= ST_OK;
            out_dist_reg       <= '0;
            out_total_reg      <= '0;
            out_mean_reg       <= '0;
            out_sd_reg         <= '0;
            out_ov_reg         <= 1'b0;
            out_oc_reg         <= '0;
        end
        else
        begin
            // output register drains on a taken beat unless a new one loads
            if (out_valid_reg && rsp.ready && !emit_go)
                out_valid_reg <= 1'b0;

            // configuration writes
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SKIP_COUNT:
                    begin
                        skip_count_reg <= cfg_data;
                        skip_left_reg  <= cfg_data;
                    end
                    CFG_STOP_ON_ALL:    stop_on_all_reg    <= cfg_data[0];
                    CFG_CHECK_OUTLIERS: check_outliers_reg <= cfg_data[0];
                    default:            ;
                endcase
            end

            // walk pipeline shared by both passes
            p1_vld_reg <= mem_re && (state_reg == S_SUM || state_reg == S_OWALK);
            p1_idx_reg <= mem_raddr;
            p2_vld_reg <= p1_vld_reg;
            c_reg      <= walk_c;
            p3_vld_reg <= p2_vld_reg;
            sq_reg     <= (2*CMAX_W)'(c_reg) * (2*CMAX_W)'(c_reg);
            nc_reg     <= NC_W'(n_reg) * NC_W'(c_reg);
            nz_reg     <= (c_reg != '0);

            case (state_reg)
                S_IDLE:
                begin
                    if (req_fire)
                    begin
                        byte_reg <= req.data_byte;
                        if (req.req_type == REQ_DATA)
                        begin
                            if (skip_left_reg != '0)
                                skip_left_reg <= skip_left_reg - 1'b1;
                            else
                                state_reg <= S_UPD;
                        end
                        else
                        begin
                            res_dist_reg  <= '0;
                            res_total_reg <= '0;
                            res_mean_reg  <= '0;
                            res_sd_reg    <= '0;
                            res_ov_reg    <= 1'b0;
                            oc_reg        <= '0;
                            if (skip_left_reg != '0)
                            begin
                                res_status_reg <= ST_SHORT;
                                state_reg      <= S_EMIT;
                            end
                            else if (distinct_reg == '0)
                            begin
                                res_status_reg <= ST_EMPTY;
                                state_reg      <= S_EMIT;
                            end
                            else
                            begin
                                n_reg     <= distinct_reg;
                                s_reg     <= '0;
                                q_reg     <= '0;
                                issue_reg <= '0;
                                state_reg <= S_SUM;
                            end
                        end
                    end
                end

                S_UPD:
                begin
                    distinct_reg  <= distinct_next;
                    run_total_reg <= run_total_next;
                    bin_vld_reg[byte_reg] <= 1'b1;
                    state_reg     <= S_IDLE;
                    if (stop_on_all_reg && upd_c == '0 && distinct_next == DIST_W'(NBINS))
                    begin
                        res_status_reg <= ST_ALL;
                        res_dist_reg   <= DIST_W'(NBINS);
                        res_total_reg  <= run_total_next;
                        res_mean_reg   <= '0;
                        res_sd_reg     <= '0;
                        res_ov_reg     <= 1'b0;
                        oc_reg         <= '0;
                        state_reg      <= S_EMIT;
                    end
                end

                // sum and sum of squares over all bins
                S_SUM:
                begin
                    if (mem_re)
                        issue_reg <= issue_reg + 1'b1;
                    if (p2_vld_reg)
                        s_reg <= s_reg + S_W'(c_reg);
                    if (p3_vld_reg)
                        q_reg <= q_reg + Q_W'(sq_reg);
                    if (walk_done)
                    begin
                        mul_a_reg   <= V_W'(q_reg);
                        mul_b_reg   <= MB_W'(n_reg);
                        mul_acc_reg <= '0;
                        step_reg    <= '0;
                        state_reg   <= S_MNQ;
                    end
                end

                // n * sum(c^2), then S * S
                S_MNQ, S_MSS:
                begin
                    mul_acc_reg <= mul_sum;
                    mul_a_reg   <= mul_a_reg << 1;
                    mul_b_reg   <= mul_b_reg >> 1;
                    step_reg    <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(MB_W - 1))
                    begin
                        step_reg <= '0;
                        if (state_reg == S_MNQ)
                        begin
                            nq_reg      <= mul_sum;
                            mul_a_reg   <= V_W'(s_reg);
                            mul_b_reg   <= MB_W'(s_reg);
                            mul_acc_reg <= '0;
                            state_reg   <= S_MSS;
                        end
                        else
                        begin
                            mul_acc_reg <= mul_sum;
                            state_reg   <= S_SUB;
                        end
                    end
                end

                S_SUB:
                begin
                    v_reg       <= nq_reg - mul_acc_reg;
                    ov_reg      <= check_outliers_reg &&
                                   ((nq_reg - mul_acc_reg) > (V_W'(n_reg) * V_W'(n_reg)));
                    sq_x_reg    <= SQ_W'({nq_reg - mul_acc_reg, 16'd0});
                    sq_rem_reg  <= '0;
                    sq_root_reg <= '0;
                    step_reg    <= '0;
                    state_reg   <= S_SQ1;
                end

                // digit-by-digit root, two radicand bits per step
                S_SQ1, S_SQ2:
                begin
                    sq_x_reg    <= sq_x_reg << 2;
                    sq_rem_reg  <= sq_ge ? rem_sh - trial : rem_sh;
                    sq_root_reg <= {sq_root_reg[RT_W-2:0], sq_ge};
                    step_reg    <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(RT_W - 1))
                    begin
                        step_reg <= '0;
                        if (state_reg == S_SQ1)
                        begin
                            div_q_reg <= DV_W'({s_reg, 8'd0});
                            div_r_reg <= '0;
                            state_reg <= S_DIVM;
                        end
                        else
                        begin
                            r2_reg    <= {sq_root_reg[RT_W-2:0], sq_ge};
                            issue_reg <= '0;
                            oc_reg    <= '0;
                            state_reg <= S_OWALK;
                        end
                    end
                end

                // restoring division by n, one quotient bit per step
                S_DIVM, S_DIVS:
                begin
                    div_r_reg <= div_ge ? DIST_W'(div_sh - {1'b0, n_reg}) : DIST_W'(div_sh);
                    div_q_reg <= {div_q_reg[DV_W-2:0], div_ge};
                    step_reg  <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(DV_W - 1))
                    begin
                        step_reg <= '0;
                        div_r_reg <= '0;
                        if (state_reg == S_DIVM)
                        begin
                            res_mean_reg <= STAT_W'({div_q_reg[DV_W-2:0], div_ge});
                            div_q_reg    <= DV_W'(sq_root_reg);
                            state_reg    <= S_DIVS;
                        end
                        else
                        begin
                            res_sd_reg     <= STAT_W'({div_q_reg[DV_W-2:0], div_ge});
                            res_status_reg <= ST_OK;
                            res_dist_reg   <= n_reg;
                            res_total_reg  <= run_total_reg;
                            res_ov_reg     <= ov_reg;
                            oc_reg         <= '0;
                            if (ov_reg)
                            begin
                                sq_x_reg    <= SQ_W'({v_reg, 2'd0});
                                sq_rem_reg  <= '0;
                                sq_root_reg <= '0;
                                state_reg   <= S_SQ2;
                            end
                            else
                            begin
                                state_reg <= S_EMIT;
                            end
                        end
                    end
                end

                // |n*c - S| > isqrt(4v) is the same test as (n*c - S)^2 > 4v
                S_OWALK:
                begin
                    if (mem_re)
                        issue_reg <= issue_reg + 1'b1;
                    if (p3_vld_reg && nz_reg && RT_W'(dist_abs) > r2_reg)
                        oc_reg <= oc_reg + 1'b1;
                    if (walk_done)
                        state_reg <= S_EMIT;
                end

                S_EMIT:
                begin
                    if (emit_go)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_status_reg <= res_status_reg;
                        out_dist_reg   <= res_dist_reg;
                        out_total_reg  <= res_total_reg;
                        out_mean_reg   <= res_mean_reg;
                        out_sd_reg     <= res_sd_reg;
                        out_ov_reg     <= res_ov_reg;
                        out_oc_reg     <= oc_reg;
                        // start a new run
                        bin_vld_reg    <= '0;
                        distinct_reg   <= '0;
                        run_total_reg  <= '0;
                        skip_left_reg  <= skip_count_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[hw/rtl/bhs_checker.sv]
module bhs_checker
    import bhs_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] status,
    input logic [DIST_W-1:0]   distinct_count,
    input logic [TOTAL_W-1:0]  total_count,
    input logic [STAT_W-1:0]   mean_q8,
    input logic [STAT_W-1:0]   std_dev_q8,
    input logic                outliers_valid,
    input logic [DIST_W-1:0]   outlier_count
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(total_count))
        else $error("result beat changed under stall");

    // short and empty runs carry no statistics
    a_short_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_SHORT || status == ST_EMPTY) |->
        distinct_count == '0 && total_count == '0 && mean_q8 == '0 && std_dev_q8 == '0)
        else $error("short or empty run with nonzero fields");

    // all-found result
    a_all: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_ALL |->
        distinct_count == DIST_W'(NBINS) && mean_q8 == '0 && !outliers_valid)
        else $error("bad all-found result");

    // outlier count only when the check ran
    a_oc: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !outliers_valid |-> outlier_count == '0)
        else $error("outlier count without outlier check");

    // stats beats come from a nonempty run
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == ST_OK |-> distinct_count != '0 && total_count != '0)
        else $error("stats result from an empty run");

endmodule

bind byte_histogram_stats_unit bhs_checker u_bhs_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .status         (rsp.status),
    .distinct_count (rsp.distinct_count),
    .total_count    (rsp.total_count),
    .mean_q8        (rsp.mean_q8),
    .std_dev_q8     (rsp.std_dev_q8),
    .outliers_valid (rsp.outliers_valid),
    .outlier_count  (rsp.outlier_count)
);
